FILE: design/lgs_pkg.sv
// Shared types, constants and the B3/S23 rule for the life generation stencil.
`default_nettype none

package lgs_pkg;

    // One column slot of the line stores: rows two back, one back and current
    typedef struct packed {
        logic older;
        logic previous;
        logic current;
    } lgs_stack_t;

    // Sequencer states of the emission control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SECOND,
        ST_FLUSH
    } lgs_state_t;

    // Register file view handed to the datapath
    typedef struct packed {
        logic [5:0] grid_width;
        logic [6:0] grid_height;
        logic       restart;
    } lgs_cfg_t;

    // Register indexes as decoded from paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Register values after reset
    localparam logic [5:0] GRID_WIDTH_RESET  = 6'd60;
    localparam logic [6:0] GRID_HEIGHT_RESET = 7'd30;

    // Next state of the centre cell; each vector is {left, centre, right}
    function automatic logic life_rule(input logic [2:0] upper,
                                       input logic [2:0] middle,
                                       input logic [2:0] lower);
        logic [3:0] n;
        n = 4'(middle[2]) + 4'(middle[0]);
        for (int i = 0; i < 3; i++) begin
            n = n + 4'(upper[i]) + 4'(lower[i]);
        end
        return (n == 4'd3) || ((n == 4'd2) && middle[1]);
    endfunction

endpackage

`default_nettype wire

FILE: design/lgs_cell_if.sv
// Input channel carrying one current generation cell per request.
`default_nettype none

interface lgs_cell_if;
    logic valid;
    logic ready;
    logic cell_alive;

    modport source (output valid, output cell_alive, input ready);
    modport sink   (input valid, input cell_alive, output ready);
endinterface

`default_nettype wire

FILE: design/lgs_result_if.sv
// Output channel carrying one next generation cell per request.
`default_nettype none

interface lgs_result_if;
    logic       valid;
    logic       ready;
    logic       next_alive;
    logic [5:0] out_row;
    logic [5:0] out_col;
    logic       frame_done;
    logic       run_last;

    modport source (output valid, output next_alive, output out_row, output out_col,
                    output frame_done, output run_last, input ready);
    modport sink   (input valid, input next_alive, input out_row, input out_col,
                    input frame_done, input run_last, output ready);
endinterface

`default_nettype wire

FILE: design/lgs_cell.sv
// One slot of the line store ring: three row bits handed on by one slot per shift.
`default_nettype none

module lgs_cell #(
    parameter int INDEX = 0,
    parameter int COL_W = 6
) (
    input  wire logic               clk,
    input  wire logic               shift,
    input  wire logic [COL_W-1:0]   w_last,
    input  wire lgs_pkg::lgs_stack_t neighbour,
    input  wire lgs_pkg::lgs_stack_t feed,
    output lgs_pkg::lgs_stack_t      stack
);
    import lgs_pkg::*;

    lgs_stack_t stack_reg;
    lgs_stack_t stack_next;

    // Take the new column when this slot closes the ring, else the neighbour
    always_comb
    begin
        stack_next = (w_last == COL_W'(INDEX)) ? feed : neighbour;
    end

    // Advance on every shift of the ring
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            stack_reg <= stack_next;
        end
    end

    assign stack = stack_reg;

endmodule

`default_nettype wire

FILE: design/lgs_ring.sv
// Chain of line store slots forming a ring of the configured row width.
`default_nettype none

module lgs_ring #(
    parameter int MAX_WIDTH = 60
) (
    input  wire logic                          clk,
    input  wire logic                          shift,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  w_last,
    input  wire lgs_pkg::lgs_stack_t           feed,
    output lgs_pkg::lgs_stack_t                tap0,
    output lgs_pkg::lgs_stack_t                tap1
);
    import lgs_pkg::*;

    localparam int ColW = $clog2(MAX_WIDTH);

    lgs_stack_t slot [MAX_WIDTH];

    // Build the chain; each slot hands its bits towards slot zero
    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_slot
        if (k == MAX_WIDTH - 1)
        begin : g_end
            lgs_cell #(.INDEX(k), .COL_W(ColW)) u_cell (
                .clk       (clk),
                .shift     (shift),
                .w_last    (w_last),
                .neighbour (feed),
                .feed      (feed),
                .stack     (slot[k])
            );
        end
        else
        begin : g_mid
            lgs_cell #(.INDEX(k), .COL_W(ColW)) u_cell (
                .clk       (clk),
                .shift     (shift),
                .w_last    (w_last),
                .neighbour (slot[k+1]),
                .feed      (feed),
                .stack     (slot[k])
            );
        end
    end

    // Oldest column and the one after it
    assign tap0 = slot[0];
    assign tap1 = slot[1];

endmodule

`default_nettype wire

FILE: design/lgs_cfg.sv
// APB register file holding grid width and grid height.
`default_nettype none

module lgs_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lgs_pkg::lgs_cfg_t cfg
);
    import lgs_pkg::*;

    logic [5:0] grid_width_reg;
    logic [5:0] grid_width_next;
    logic [6:0] grid_height_reg;
    logic [6:0] grid_height_next;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // Decode the write
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (wr)
        begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  grid_width_next  = pwdata[5:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[6:0];
                default:         grid_width_next  = grid_width_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = {26'd0, grid_width_reg};
            REG_GRID_HEIGHT: prdata = {25'd0, grid_height_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.grid_width  = grid_width_reg;
    assign cfg.grid_height = grid_height_reg;
    assign cfg.restart     = wr;

endmodule

`default_nettype wire

FILE: design/life_generation_stencil_unit.sv
// Top level of the streaming B3/S23 life generation stencil.
//
//  channel   | direction | handshake      | payload
//  ----------+-----------+----------------+------------------------------------------
//  cells     | in        | valid / ready  | cell_alive
//  results   | out       | valid / ready  | next_alive, out_row, out_col,
//            |           |                | frame_done, run_last
//  apb       | in        | psel / penable | paddr, pwdata, prdata (pready tied high)
//
//  A cell's result, if any, is loaded into the output register as the cell is taken.
//  Past the first row, a row end with two or more columns holds input in ST_SECOND
//  until its second result is sent. The last cell of a frame adds a flush of W
//  results, one per column, read from the oldest ring slot. A
//  stalled output holds the sequencer; input is taken while a result waits only if
//  that result is taken in the same cycle. Reset clears positions and handshakes.
`default_nettype none

module life_generation_stencil_unit #(
    parameter int MAX_WIDTH  = 60,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lgs_cell_if.sink         cells,
    lgs_result_if.source     results,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lgs_pkg::*;

    localparam int         ColW    = $clog2(MAX_WIDTH);
    localparam int         HCapInt = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
    localparam int         RowW    = $clog2(HCapInt);
    localparam logic [5:0] WCap    = 6'(MAX_WIDTH);
    localparam logic [6:0] HCap    = 7'(HCapInt);

    lgs_cfg_t   cfg;
    lgs_stack_t tap0;
    lgs_stack_t tap1;
    lgs_stack_t t_new;
    lgs_stack_t ring_feed;
    logic       ring_shift;

    logic [ColW-1:0] w_last;
    logic [RowW-1:0] h_last;

    lgs_state_t      state_reg,    state_next;
    logic [RowW-1:0] row_reg,      row_next;
    logic [ColW-1:0] col_reg,      col_next;
    lgs_stack_t      win1_reg,     win1_next;
    lgs_stack_t      win2_reg,     win2_next;
    lgs_stack_t      left_reg,     left_next;
    logic            sec_alive_reg, sec_alive_next;
    logic [5:0]      sec_row_reg,  sec_row_next;
    logic [5:0]      sec_col_reg,  sec_col_next;
    logic            sec_last_reg, sec_last_next;
    logic            flush_pend_reg,   flush_pend_next;
    logic            flush_top_ok_reg, flush_top_ok_next;
    logic [5:0]      flush_row_reg,    flush_row_next;
    logic [ColW-1:0] flush_col_reg,    flush_col_next;
    logic            res_valid_reg, res_valid_next;
    logic            res_alive_reg, res_alive_next;
    logic [5:0]      res_row_reg,   res_row_next;
    logic [5:0]      res_col_reg,   res_col_next;
    logic            res_done_reg,  res_done_next;
    logic            res_last_reg,  res_last_next;

    logic       out_free;
    logic       cell_ready;
    logic       acc;
    logic       flush_step;
    logic       row_end;
    logic       frame_end;
    logic       top_ok;
    logic       lm1;
    logic       lm2;
    logic       lv;
    logic       rv;
    logic       e1_alive;
    logic       e2_alive;
    logic       fl_alive;
    logic [5:0] row_m1;

    // Register file
    lgs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp the configured size to the supported range
    always_comb
    begin
        priority if (cfg.grid_width == 6'd0)
            w_last = '0;
        else if (cfg.grid_width > WCap)
            w_last = ColW'(WCap - 6'd1);
        else
            w_last = ColW'(cfg.grid_width - 6'd1);

        priority if (cfg.grid_height == 7'd0)
            h_last = '0;
        else if (cfg.grid_height > HCap)
            h_last = RowW'(HCap - 7'd1);
        else
            h_last = RowW'(cfg.grid_height - 7'd1);
    end

    // Handshake and position decode
    assign out_free   = !res_valid_reg || results.ready;
    assign cell_ready = (state_reg == ST_IDLE) && out_free;
    assign acc        = cells.valid && cell_ready;
    assign flush_step = (state_reg == ST_FLUSH) && out_free;
    assign row_end    = (col_reg == w_last);
    assign frame_end  = row_end && (row_reg == h_last);
    assign row_m1     = 6'(row_reg - RowW'(1));

    // New column of the window: two rows from the ring plus the incoming cell
    assign t_new.older    = tap0.previous;
    assign t_new.previous = tap0.current;
    assign t_new.current  = cells.cell_alive;

    // Rotate the ring on each accepted cell and each flush step
    assign ring_shift = acc || flush_step;
    assign ring_feed  = (state_reg == ST_FLUSH) ? tap0 : t_new;

    lgs_ring #(.MAX_WIDTH(MAX_WIDTH)) u_ring (
        .clk    (clk),
        .shift  (ring_shift),
        .w_last (w_last),
        .feed   (ring_feed),
        .tap0   (tap0),
        .tap1   (tap1)
    );

    // Judge the cell one row up and one column back, then the row's last column
    assign top_ok = (row_reg >= RowW'(2));
    assign lm1    = (col_reg >= ColW'(2));
    assign lm2    = (col_reg != '0);

    assign e1_alive = life_rule(
        {win2_reg.older & lm1, win1_reg.older, t_new.older} & {3{top_ok}},
        {win2_reg.previous & lm1, win1_reg.previous, t_new.previous},
        {win2_reg.current & lm1, win1_reg.current, t_new.current});

    assign e2_alive = life_rule(
        {win1_reg.older & lm2, t_new.older, 1'b0} & {3{top_ok}},
        {win1_reg.previous & lm2, t_new.previous, 1'b0},
        {win1_reg.current & lm2, t_new.current, 1'b0});

    // Judge the last row during the flush; below it everything is dead
    assign lv = (flush_col_reg != '0);
    assign rv = (flush_col_reg != w_last);

    assign fl_alive = life_rule(
        {left_reg.previous & lv, tap0.previous, tap1.previous & rv} & {3{flush_top_ok_reg}},
        {left_reg.current & lv, tap0.current, tap1.current & rv},
        3'b000);

    // Sequencer: next state, positions and the output register
    always_comb
    begin
        state_next        = state_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        win1_next         = win1_reg;
        win2_next         = win2_reg;
        left_next         = left_reg;
        sec_alive_next    = sec_alive_reg;
        sec_row_next      = sec_row_reg;
        sec_col_next      = sec_col_reg;
        sec_last_next     = sec_last_reg;
        flush_pend_next   = flush_pend_reg;
        flush_top_ok_next = flush_top_ok_reg;
        flush_row_next    = flush_row_reg;
        flush_col_next    = flush_col_reg;
        res_valid_next    = res_valid_reg && !results.ready;
        res_alive_next    = res_alive_reg;
        res_row_next      = res_row_reg;
        res_col_next      = res_col_reg;
        res_done_next     = res_done_reg;
        res_last_next     = res_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    win2_next = win1_reg;
                    win1_next = t_new;

                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = frame_end ? '0 : row_reg + RowW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + ColW'(1);
                    end

                    // Keep the second result and the flush set-up
                    sec_alive_next    = e2_alive;
                    sec_row_next      = row_m1;
                    sec_col_next      = 6'(w_last);
                    sec_last_next     = !frame_end;
                    flush_pend_next   = frame_end;
                    flush_top_ok_next = (row_reg != '0);
                    flush_row_next    = 6'(row_reg);
                    flush_col_next    = '0;

                    priority if ((row_reg != '0) && (col_reg != '0))
                    begin
                        res_valid_next = 1'b1;
                        res_alive_next = e1_alive;
                        res_row_next   = row_m1;
                        res_col_next   = 6'(col_reg - ColW'(1));
                        res_done_next  = 1'b0;
                        res_last_next  = !row_end;
                        state_next     = row_end ? ST_SECOND : ST_IDLE;
                    end
                    else if ((row_reg != '0) && row_end)
                    begin
                        res_valid_next = 1'b1;
                        res_alive_next = e2_alive;
                        res_row_next   = row_m1;
                        res_col_next   = 6'(w_last);
                        res_done_next  = 1'b0;
                        res_last_next  = !frame_end;
                        state_next     = frame_end ? ST_FLUSH : ST_IDLE;
                    end
                    else if (frame_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SECOND:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_alive_next = sec_alive_reg;
                    res_row_next   = sec_row_reg;
                    res_col_next   = sec_col_reg;
                    res_done_next  = 1'b0;
                    res_last_next  = sec_last_reg;
                    state_next     = flush_pend_reg ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (flush_step)
                begin
                    res_valid_next = 1'b1;
                    res_alive_next = fl_alive;
                    res_row_next   = flush_row_reg;
                    res_col_next   = 6'(flush_col_reg);
                    res_done_next  = !rv;
                    res_last_next  = !rv;
                    left_next      = tap0;
                    flush_col_next = flush_col_reg + ColW'(1);
                    if (!rv)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop to the start of a frame on any register write
        if (cfg.restart)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            res_valid_reg  <= 1'b0;
            flush_pend_reg <= 1'b0;
            flush_col_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            res_valid_reg  <= res_valid_next;
            flush_pend_reg <= flush_pend_next;
            flush_col_reg  <= flush_col_next;
        end
    end

    // Window and payload
    always_ff @(posedge clk)
    begin
        win1_reg         <= win1_next;
        win2_reg         <= win2_next;
        left_reg         <= left_next;
        sec_alive_reg    <= sec_alive_next;
        sec_row_reg      <= sec_row_next;
        sec_col_reg      <= sec_col_next;
        sec_last_reg     <= sec_last_next;
        flush_top_ok_reg <= flush_top_ok_next;
        flush_row_reg    <= flush_row_next;
        res_alive_reg    <= res_alive_next;
        res_row_reg      <= res_row_next;
        res_col_reg      <= res_col_next;
        res_done_reg     <= res_done_next;
        res_last_reg     <= res_last_next;
    end

    // Drive the channels
    assign cells.ready        = cell_ready;
    assign results.valid      = res_valid_reg;
    assign results.next_alive = res_alive_reg;
    assign results.out_row    = res_row_reg;
    assign results.out_col    = res_col_reg;
    assign results.frame_done = res_done_reg;
    assign results.run_last   = res_last_reg;

    // The final cell of a frame also closes its request's run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_done |-> results.run_last)
        else $error("frame_done without run_last");

    // A row end returns the column to zero
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        acc && row_end |=> col_reg == '0)
        else $error("column did not wrap at row end");

    // The second result always follows a result still held
    a_second_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SECOND |-> res_valid_reg)
        else $error("second result pending with empty output register");

    // A result that does not close its run means more are on the way
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.run_last |-> state_reg != ST_IDLE)
        else $error("open run while sequencer idle");

endmodule

`default_nettype wire

FILE: tb/tb_life_generation_stencil_unit.sv
// Self-checking testbench for the streaming B3/S23 life generation stencil.
`default_nettype none

module tb_life_generation_stencil_unit;
    import lgs_pkg::*;

    localparam int MAX_W         = 60;
    localparam int MAX_H         = 64;
    localparam int RANDOM_CELLS  = 470;
    localparam int DRAIN_CYCLES  = 8;
    localparam int DIRECTED_ROWS = 28;
    localparam logic [2:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

    // One emitted cell of the next generation
    typedef struct packed {
        logic       next_alive;
        logic [5:0] out_row;
        logic [5:0] out_col;
        logic       frame_done;
        logic       run_last;
    } gen_cell_t;

    typedef enum logic [1:0] {
        ROW_CELL,
        ROW_SET_WIDTH,
        ROW_SET_HEIGHT
    } stim_kind_t;

    // Directed stimulus row; last_alive is checked only where typed is set
    typedef struct packed {
        stim_kind_t kind;
        logic [6:0] value;
        logic       typed;
        logic       last_alive;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lgs_cell_if   cells_if();
    lgs_result_if results_if();

    life_generation_stencil_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cells_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: line stores, raster position and register copies
    bit [MAX_W-1:0] older_row;
    bit [MAX_W-1:0] prev_row;
    bit [MAX_W-1:0] cur_row;
    int             row_pos;
    int             col_pos;
    logic [5:0]     width_reg;
    logic [6:0]     height_reg;

    gen_cell_t pending_next_gen[$];

    int  fail_count;
    int  cells_sent;
    int  rand_cells;
    int  cells_checked;
    int  frames_checked;
    int  settings_used;
    int  burst_left;
    bit  quiet;

    // Directed part: idle default grid, blinker, full block, then degenerate grids
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd0,  1'b0, 1'b0},
        '{ROW_SET_WIDTH,  7'd3,  1'b0, 1'b0},
        '{ROW_SET_HEIGHT, 7'd3,  1'b0, 1'b0},
        '{ROW_CELL,       7'd0,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd0,  1'b0, 1'b0},
        '{ROW_CELL,       7'd0,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b1, 1'b0},
        '{ROW_CELL,       7'd0,  1'b1, 1'b0},
        '{ROW_CELL,       7'd0,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b1, 1'b1},
        '{ROW_CELL,       7'd0,  1'b1, 1'b0},
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b1, 1'b1},
        '{ROW_CELL,       7'd1,  1'b1, 1'b1},
        '{ROW_CELL,       7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b1, 1'b0},
        '{ROW_CELL,       7'd1,  1'b1, 1'b1},
        '{ROW_SET_WIDTH,  7'd0,  1'b0, 1'b0},
        '{ROW_SET_HEIGHT, 7'd0,  1'b0, 1'b0},
        '{ROW_CELL,       7'd1,  1'b1, 1'b0},
        '{ROW_SET_WIDTH,  7'd1,  1'b0, 1'b0},
        '{ROW_SET_HEIGHT, 7'd1,  1'b0, 1'b0},
        '{ROW_CELL,       7'd0,  1'b1, 1'b0}
    };

    // Clamp a grid dimension into 1..hi
    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bit cell_at(input bit [MAX_W-1:0] row, input bit ok,
                                   input int col, input int w);
        if (!ok || col < 0 || col >= w)
            return 1'b0;
        return row[col];
    endfunction

    // B3/S23 on the cell at col of mid, with top and bottom rows gated
    function automatic bit life_next(input bit [MAX_W-1:0] top, input bit top_ok,
                                     input bit [MAX_W-1:0] mid,
                                     input bit [MAX_W-1:0] bot, input bit bot_ok,
                                     input int col, input int w);
        int n;
        n = cell_at(mid, 1'b1, col - 1, w) + cell_at(mid, 1'b1, col + 1, w);
        for (int d = -1; d <= 1; d++)
            n += cell_at(top, top_ok, col + d, w) + cell_at(bot, bot_ok, col + d, w);
        if (n == 3)
            return 1'b1;
        if (n == 2)
            return cell_at(mid, 1'b1, col, w);
        return 1'b0;
    endfunction

    function automatic void queue_cell(input bit alive, input int row, input int col);
        gen_cell_t g;
        g            = '0;
        g.next_alive = alive;
        g.out_row    = 6'(row);
        g.out_col    = 6'(col);
        pending_next_gen.push_back(g);
    endfunction

    // Work out the cells released by one accepted request; returns their number
    function automatic int predict_generation(input bit alive);
        int w;
        int h;
        int r;
        int c;
        int k;
        bit row_end;
        bit frame_end;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        r = row_pos;
        c = col_pos;
        k = 0;
        if (c >= w)
            c = w - 1;
        if (r >= h)
            r = h - 1;
        cur_row[c] = alive;
        row_end    = (c == w - 1);
        frame_end  = row_end && (r == h - 1);

        // Judge the row above once its lower neighbours have arrived
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                queue_cell(life_next(older_row, r >= 2, prev_row, cur_row, 1'b1, c - 1, w),
                           r - 1, c - 1);
                k++;
            end
            if (row_end)
            begin
                queue_cell(life_next(older_row, r >= 2, prev_row, cur_row, 1'b1, w - 1, w),
                           r - 1, w - 1);
                k++;
            end
        end

        // Flush the last row with nothing below it
        if (frame_end)
        begin
            for (int i = 0; i < w; i++)
            begin
                queue_cell(life_next(prev_row, r >= 1, cur_row, cur_row, 1'b0, i, w), r, i);
                k++;
            end
            pending_next_gen[pending_next_gen.size() - 1].frame_done = 1'b1;
        end
        if (k > 0)
            pending_next_gen[pending_next_gen.size() - 1].run_last = 1'b1;

        // Advance the raster position and rotate the line stores
        if (row_end)
        begin
            older_row = prev_row;
            prev_row  = cur_row;
            col_pos   = 0;
            row_pos   = frame_end ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        return k;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net against a hung handshake
    initial
    begin
        #(30_000_000);
        $display("life_generation_stencil_unit test failed");
        $finish;
    end

    // Receiver: stretches of full acceptance, random acceptance and long stalls
    initial
    begin : result_stall
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 60);
            for (int i = 0; i < span; i++)
            begin
                case (mode)
                    0:       results_if.ready <= 1'b1;
                    1:       results_if.ready <= 1'($urandom_range(0, 1));
                    default: results_if.ready <= ($urandom_range(0, 9) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        gen_cell_t exp_cell;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_next_gen.size() == 0)
            begin
                $error("unexpected result at row %0d col %0d",
                       results_if.out_row, results_if.out_col);
                fail_count++;
            end
            else
            begin
                exp_cell = pending_next_gen.pop_front();
                cells_checked++;
                if (results_if.frame_done)
                    frames_checked++;
                if (results_if.next_alive !== exp_cell.next_alive)
                begin
                    $error("next_alive: expected %0d, got %0d",
                           exp_cell.next_alive, results_if.next_alive);
                    fail_count++;
                end
                if (results_if.out_row !== exp_cell.out_row)
                begin
                    $error("out_row: expected %0d, got %0d",
                           exp_cell.out_row, results_if.out_row);
                    fail_count++;
                end
                if (results_if.out_col !== exp_cell.out_col)
                begin
                    $error("out_col: expected %0d, got %0d",
                           exp_cell.out_col, results_if.out_col);
                    fail_count++;
                end
                if (results_if.frame_done !== exp_cell.frame_done)
                begin
                    $error("frame_done: expected %0d, got %0d",
                           exp_cell.frame_done, results_if.frame_done);
                    fail_count++;
                end
                if (results_if.run_last !== exp_cell.run_last)
                begin
                    $error("run_last: expected %0d, got %0d",
                           exp_cell.run_last, results_if.run_last);
                    fail_count++;
                end
            end
        end
    end

    // Offer one cell, honouring bursts and gaps; predict on acceptance
    task automatic send_cell(input bit alive, input bit typed, input bit typed_alive);
        int n;
        if (burst_left == 0)
        begin
            cells_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = quiet ? 1_000_000 : $urandom_range(1, 24);
        end
        cells_if.valid      <= 1'b1;
        cells_if.cell_alive <= alive;
        do @(posedge clk); while (!cells_if.ready);
        burst_left--;
        cells_sent++;
        n = predict_generation(alive);
        if (typed && n > 0)
            pending_next_gen[pending_next_gen.size() - 1].next_alive = typed_alive;
    endtask

    // Drop valid and wait until the block has drained
    task automatic settle();
        cells_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_next_gen.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic read_check(input logic [2:0] addr, input logic [31:0] expected);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== expected)
        begin
            $error("prdata at %0d: expected %0d, got %0d", addr, expected, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, mirror it in the predictor and read it back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_GRID_WIDTH)
            width_reg = data[5:0];
        else
            height_reg = data[6:0];
        row_pos = 0;
        col_pos = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_GRID_WIDTH)
            read_check(addr, 32'(width_reg));
        else
            read_check(addr, 32'(height_reg));
    endtask

    // Main sequence
    initial
    begin
        int wv;
        int hv;
        int n;
        int density;
        logic [31:0] data;

        cells_if.valid      <= 1'b0;
        cells_if.cell_alive <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        older_row  = '0;
        prev_row   = '0;
        cur_row    = '0;
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = 6'd60;
        height_reg = 7'd30;
        fail_count     = 0;
        cells_sent     = 0;
        rand_cells     = 0;
        cells_checked  = 0;
        frames_checked = 0;
        settings_used  = 0;
        burst_left     = 0;
        quiet          = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers must come up at their reset values
        read_check(ADDR_GRID_WIDTH, 32'd60);
        read_check(ADDR_GRID_HEIGHT, 32'd30);

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            case (directed_rows[i].kind)
                ROW_SET_WIDTH:
                begin
                    settle();
                    write_reg(ADDR_GRID_WIDTH, 32'(directed_rows[i].value));
                    settings_used++;
                end
                ROW_SET_HEIGHT:
                begin
                    settle();
                    write_reg(ADDR_GRID_HEIGHT, 32'(directed_rows[i].value));
                end
                default:
                    send_cell(directed_rows[i].value[0], directed_rows[i].typed,
                              directed_rows[i].last_alive);
            endcase
        end

        // Random phases: new grid, then whole frames or a broken one
        for (int phase = 0; rand_cells < RANDOM_CELLS; phase++)
        begin
            case (phase)
                0:
                begin
                    wv = 63;
                    hv = 2;
                end
                1:
                begin
                    wv = 1;
                    hv = 127;
                end
                default:
                begin
                    case ($urandom_range(0, 15))
                        0:       wv = 0;
                        1:       wv = 60;
                        2:       wv = $urandom_range(59, 63);
                        default: wv = $urandom_range(1, 8);
                    endcase
                    case ($urandom_range(0, 15))
                        0:       hv = 0;
                        1:       hv = 64;
                        2:       hv = $urandom_range(63, 127);
                        default: hv = $urandom_range(1, 8);
                    endcase
                    if (clamp_dim(wv, MAX_W) * clamp_dim(hv, MAX_H) > 130)
                        hv = $urandom_range(0, 2);
                end
            endcase

            settle();
            data      = $urandom();
            data[5:0] = 6'(wv);
            write_reg(ADDR_GRID_WIDTH, data);
            data      = $urandom();
            data[6:0] = 7'(hv);
            write_reg(ADDR_GRID_HEIGHT, data);
            settings_used++;

            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       density = 12;
                1:       density = 50;
                default: density = 85;
            endcase
            n = clamp_dim(wv, MAX_W) * clamp_dim(hv, MAX_H);
            if (phase >= 2)
                n = n * $urandom_range(1, 3);
            // Cut the stream short now and then; the next write restarts the frame
            if ($urandom_range(0, 5) == 0)
                n = $urandom_range(1, n);
            // Hold the total near the intended count
            if (n > RANDOM_CELLS - rand_cells)
                n = RANDOM_CELLS - rand_cells;
            for (int i = 0; i < n; i++)
                send_cell($urandom_range(0, 99) < density, 1'b0, 1'b0);
            rand_cells += n;
        end

        settle();
        $display("Sent %0d cells over %0d grid settings, from 1x1 up to 60 wide and 64 high.",
                 cells_sent, settings_used);
        $display("Checked %0d next-generation cells across %0d completed frames.",
                 cells_checked, frames_checked);
        if (fail_count == 0)
            $display("life_generation_stencil_unit test passed");
        else
            $display("life_generation_stencil_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
